>>> rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation pipeline.
package bsc_pkg;

  localparam int RawW = 20;
  localparam int WordW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int DivStages = 32;

  localparam logic [CfgIdxW-1:0] REG_T1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_T2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_T3 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_P1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_P2_P5 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_P6_P9 = 3'd5;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [63:0] p2_p5;
    logic [63:0] p6_p9;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

>>> rtl/core/bsc_divider.sv
// Pipelined restoring 32-bit unsigned divider with side payload.
module bsc_divider #(
  parameter int SideW = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      dividend,
  input  logic [31:0]      divisor,
  input  logic [SideW-1:0] side_in,
  output logic             out_valid,
  output logic [31:0]      quotient,
  output logic [SideW-1:0] side_out
);
  import bsc_pkg::*;

  logic [DivStages:0]       vld;
  logic [31:0]              quo [DivStages+1];
  logic [32:0]              rem [DivStages+1];
  logic [31:0]              dsr [DivStages+1];
  logic [SideW-1:0]         sd  [DivStages+1];

  always_comb begin
    vld[0] = in_valid;
    quo[0] = dividend;
    rem[0] = '0;
    dsr[0] = divisor;
    sd[0]  = side_in;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;
    always_comb begin
      shifted = {rem[s][31:0], quo[s][31]};
      diff = shifted - {1'b0, dsr[s]};
      ge = shifted >= {1'b0, dsr[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1] <= ge ? diff : shifted;
        quo[s+1] <= {quo[s][30:0], ge};
        dsr[s+1] <= dsr[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[DivStages];
  assign quotient  = quo[DivStages];
  assign side_out  = sd[DivStages];
endmodule

>>> rtl/core/bsc_front.sv
// Temperature, t_fine and pressure divisor stages.
module bsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  bsc_pkg::cal_t         cal,
  input  logic                  in_valid,
  input  logic [19:0]           adc_p,
  input  logic [19:0]           adc_t,
  output logic                  out_valid,
  output logic [31:0]           temp,
  output logic [31:0]           num,
  output logic [31:0]           den
);
  import bsc_pkg::*;

  // stage 1: temperature differences
  logic        v1q;
  logic [31:0] a1, d1;
  logic [19:0] ap1;
  // stage 2
  logic        v2q;
  logic [31:0] va2, dd2;
  logic [19:0] ap2;
  // stage 3
  logic        v3q;
  logic [31:0] va3, vb3;
  logic [19:0] ap3;
  // stage 4: t_fine
  logic        v4q;
  logic [31:0] tf4;
  logic [19:0] ap4;
  // stage 5
  logic        v5q;
  logic [31:0] tp5, pv1, pt5;
  logic [19:0] ap5;
  // stage 6: products
  logic        v6q;
  logic [31:0] tp6, m6a, m6b, pq6;
  logic [19:0] ap6;
  // stage 7
  logic        v7q;
  logic [31:0] tp7, v2s7, v1s7;
  logic [19:0] ap7;
  // stage 8
  logic        v8q;
  logic [31:0] tp8, v18, n8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1q <= 1'b0; v2q <= 1'b0; v3q <= 1'b0; v4q <= 1'b0;
      v5q <= 1'b0; v6q <= 1'b0; v7q <= 1'b0; v8q <= 1'b0;
    end else if (en) begin
      v1q <= in_valid; v2q <= v1q; v3q <= v2q; v4q <= v3q;
      v5q <= v4q; v6q <= v5q; v7q <= v6q; v8q <= v7q;
    end
    if (en) begin
      a1  <= {15'd0, adc_t[19:3]} - {15'd0, cal.t1, 1'b0};
      d1  <= {16'd0, adc_t[19:4]} - {16'd0, cal.t1};
      ap1 <= adc_p;
      va2 <= asr(a1 * sx16(cal.t2), 11);
      dd2 <= asr(d1 * d1, 12);
      ap2 <= ap1;
      va3 <= va2;
      vb3 <= asr(dd2 * sx16(cal.t3), 14);
      ap3 <= ap2;
      tf4 <= va3 + vb3;
      ap4 <= ap3;
      tp5 <= tf4 * 32'd5 + 32'd128;
      pv1 <= asr(tf4, 1) - 32'd64000;
      pt5 <= asr(asr(tf4, 1) - 32'd64000, 2);
      ap5 <= ap4;
      // q = (v1>>2)^2
      pq6 <= pt5 * pt5;
      m6a <= pv1 * sx16(cal.p2_p5[63:48]);
      m6b <= pv1 * sx16(cal.p2_p5[15:0]);
      tp6 <= asr(tp5, 8);
      ap6 <= ap5;
      v2s7 <= asr(asr(pq6, 11) * sx16(cal.p6_p9[15:0]) + (m6a << 1), 2)
              + (sx16(cal.p2_p5[47:32]) << 16);
      v1s7 <= asr(asr(sx16(cal.p2_p5[31:16]) * asr(pq6, 13), 3)
              + asr(m6b, 1), 18);
      tp7 <= tp6;
      ap7 <= ap6;
      v18 <= (32'd32768 + v1s7) * {16'd0, cal.p1};
      n8  <= ((32'd1048576 - {12'd0, ap7}) - asr(v2s7, 12)) * 32'd3125;
      tp8 <= tp7;
    end
  end

  assign out_valid = v8q;
  assign temp = tp8;
  assign num  = n8;
  assign den  = asr(v18, 15);
endmodule

>>> rtl/core/bsc_back.sv
// Final pressure correction stages after the division.
module bsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bsc_pkg::cal_t cal,
  input  logic          in_valid,
  input  logic [31:0]   quo,
  input  logic          big,
  input  logic          nz,
  input  logic [31:0]   temp_in,
  output logic          out_valid,
  output logic [31:0]   temp,
  output logic [31:0]   pres,
  output logic          pvalid
);
  import bsc_pkg::*;

  logic        v1q, v2q, v3q, v4q;
  logic [31:0] p1q, p2q, p3q, p4q, q2, m3a, m3b, t1q, t2q, t3q, t4q;
  logic        z1, z2, z3, z4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1q <= 1'b0; v2q <= 1'b0; v3q <= 1'b0; v4q <= 1'b0;
    end else if (en) begin
      v1q <= in_valid; v2q <= v1q; v3q <= v2q; v4q <= v3q;
    end
    if (en) begin
      p1q <= big ? {quo[30:0], 1'b0} : quo;
      z1  <= nz;
      t1q <= temp_in;
      q2  <= {3'd0, p1q[31:3]} * {3'd0, p1q[31:3]};
      p2q <= p1q; z2 <= z1; t2q <= t1q;
      m3a <= asr(sx16(cal.p6_p9[63:48]) * {13'd0, q2[31:13]}, 12);
      m3b <= asr({2'd0, p2q[31:2]} * sx16(cal.p6_p9[47:32]), 13);
      p3q <= p2q; z3 <= z2; t3q <= t2q;
      p4q <= z3 ? p3q + asr(m3a + m3b + sx16(cal.p6_p9[31:16]), 4) : 32'd0;
      z4  <= z3; t4q <= t3q;
    end
  end

  assign out_valid = v4q;
  assign temp = t4q;
  assign pres = p4q;
  assign pvalid = z4;
endmodule

>>> rtl/core/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation pipeline.
// Registered stages: 8 front, 32 divider, 4 back, 1 output register.
// Throughput: one word per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken.
// Synchronous reset clears valid bits and calibration registers to zero.
module baro_sensor_compensation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsc_pkg::RawW-1:0]     raw_pressure,
  input  logic [bsc_pkg::RawW-1:0]     raw_temperature,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bsc_pkg::CfgDataW-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           temperature_centi_c,
  output logic [31:0]                  pressure_pa,
  output logic                         pressure_valid
);
  import bsc_pkg::*;

  cal_t cal;
  logic en;
  logic fv, dv_in, dv, bv;
  logic [31:0] ftemp, fnum, fden, dq, btemp, bpres;
  logic [31:0] dnd;
  logic pv;
  logic [33:0] side_in, side_out;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_T1:    cal.t1 <= cfg_data[15:0];
        REG_T2:    cal.t2 <= cfg_data[15:0];
        REG_T3:    cal.t3 <= cfg_data[15:0];
        REG_P1:    cal.p1 <= cfg_data[15:0];
        REG_P2_P5: cal.p2_p5 <= cfg_data;
        REG_P6_P9: cal.p6_p9 <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk, .rst, .en, .cal,
    .in_valid(in_valid && in_ready),
    .adc_p(raw_pressure), .adc_t(raw_temperature),
    .out_valid(fv), .temp(ftemp), .num(fnum), .den(fden)
  );

  // big numerators divide first, then double
  assign dnd = fnum[31] ? fnum : {fnum[30:0], 1'b0};
  assign side_in = {fnum[31], (fden != 32'd0), ftemp};
  assign dv_in = fv;

  bsc_divider #(.SideW(34)) u_div (
    .clk, .rst, .en, .in_valid(dv_in), .dividend(dnd),
    .divisor((fden == 32'd0) ? 32'd1 : fden), .side_in,
    .out_valid(dv), .quotient(dq), .side_out
  );

  bsc_back u_back (
    .clk, .rst, .en, .cal, .in_valid(dv), .quo(dq),
    .big(side_out[33]), .nz(side_out[32]), .temp_in(side_out[31:0]),
    .out_valid(bv), .temp(btemp), .pres(bpres), .pvalid(pv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= bv;
    end
    if (en) begin
      temperature_centi_c <= btemp;
      pressure_pa <= bpres;
      pressure_valid <= pv;
    end
  end
endmodule

>>> rtl/core/bsc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pressure_pa,
  input logic        pressure_valid
);
  a_pres_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_pa == 32'd0) else $error("bad pressure");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa)) else $error("dropped word");
  a_cfg: assert property (@(posedge clk) cfg_ready) else $error("cfg stall");
endmodule

bind baro_sensor_compensation bsc_checker u_chk (
  .clk, .rst, .in_ready, .cfg_ready, .out_valid, .out_ready, .pressure_pa, .pressure_valid
);
